// ===== rtl/ptbc_pkg.sv =====
// Shared types and constants for the pixel threshold, bounding box and centroid block.
package ptbc_pkg;

   localparam int WIDTH_MAX  = 4096;
   localparam int HEIGHT_MAX = 4096;

   localparam int SAMPLE_W = 16;
   localparam int WIDTH_W  = 13;
   localparam int LEVEL_W  = 8;
   localparam int COORD_W  = 12;
   localparam int SUM_W    = 36;
   localparam int CNT_W    = 25;
   localparam int LABEL_W  = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [LABEL_W-1:0] LABEL_BGD      = 2'd0;
   localparam logic [LABEL_W-1:0] LABEL_PROB_BGD = 2'd2;
   localparam logic [LABEL_W-1:0] LABEL_PROB_FGD = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_MIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FGD_THRESHOLD = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BGD_THRESHOLD = 3'd4;

   typedef struct packed {
      logic                  we;
      logic [CSR_IDX_W-1:0]  index;
      logic [SAMPLE_W-1:0]   wdata;
   } csr_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                frame_end;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic               frame_done;
      logic               no_foreground;
      logic [COORD_W-1:0] centroid_x;
      logic [COORD_W-1:0] centroid_y;
      logic [COORD_W-1:0] box_left;
      logic [COORD_W-1:0] box_top;
      logic [COORD_W-1:0] box_right;
      logic [COORD_W-1:0] box_bottom;
   } rsp_type;

   // One classified pixel passed from the front end to the accumulators.
   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
      logic               last;
   } pixel_type;

endpackage

// ===== rtl/ptbc_front.sv =====
// Front end: configuration registers, sample rescaling divider, labelling and pixel position.
module ptbc_front (
   input  logic                clock,
   input  logic                reset,
   input  ptbc_pkg::csr_type   csr,
   input  logic                req_push,
   output logic                req_full,
   input  ptbc_pkg::req_type   req_data,
   output logic                q_push,
   input  logic                q_full,
   output ptbc_pkg::pixel_type q_data
);

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_DIV  = 3'b010,
      F_SEND = 3'b100
   } front_state_type;

   localparam logic [3:0] SAT_STEP = 4'd8;

   front_state_type state_ff, state_in;

   logic [ptbc_pkg::WIDTH_W-1:0]  width_ff;
   logic [ptbc_pkg::SAMPLE_W-1:0] min_ff, max_ff;
   logic [ptbc_pkg::LEVEL_W-1:0]  fgd_ff, bgd_ff;

   logic [25:0] rem_ff, rem_in;
   logic [24:0] den_ff, den_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [ptbc_pkg::LEVEL_W-1:0] quot_ff, quot_in;
   logic        last_ff, last_in;
   logic [ptbc_pkg::COORD_W-1:0] col_ff, col_in, row_ff, row_in;

   logic                          flat, low, ge, wrap;
   logic [ptbc_pkg::SAMPLE_W-1:0] diff, range;
   logic [25:0]                   numer, rem_sub;
   logic [ptbc_pkg::WIDTH_W-1:0]  w_eff, col_next;
   logic [ptbc_pkg::LABEL_W-1:0]  label;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= 13'd640;
         min_ff   <= 16'd0;
         max_ff   <= 16'd65280;
         fgd_ff   <= 8'd70;
         bgd_ff   <= 8'd20;
      end else if (csr.we) begin
         unique case (csr.index)
            ptbc_pkg::REG_FRAME_WIDTH:   width_ff <= csr.wdata[ptbc_pkg::WIDTH_W-1:0];
            ptbc_pkg::REG_SAMPLE_MIN:    min_ff   <= csr.wdata;
            ptbc_pkg::REG_SAMPLE_MAX:    max_ff   <= csr.wdata;
            ptbc_pkg::REG_FGD_THRESHOLD: fgd_ff   <= csr.wdata[ptbc_pkg::LEVEL_W-1:0];
            ptbc_pkg::REG_BGD_THRESHOLD: bgd_ff   <= csr.wdata[ptbc_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      flat  = max_ff <= min_ff;
      low   = req_data.sample <= min_ff;
      diff  = req_data.sample - min_ff;
      range = max_ff - min_ff;
      // 510*d + r, the tie-rounding numerator over a denominator of 2*r
      numer = {1'b0, diff, 9'b0} - {9'b0, diff, 1'b0} + {10'b0, range};
      ge      = rem_ff >= {1'b0, den_ff};
      rem_sub = rem_ff - {1'b0, den_ff};

      if (width_ff == '0) begin
         w_eff = 13'd1;
      end else if (width_ff > 13'(ptbc_pkg::WIDTH_MAX)) begin
         w_eff = 13'(ptbc_pkg::WIDTH_MAX);
      end else begin
         w_eff = width_ff;
      end
      col_next = {1'b0, col_ff} + 13'd1;
      wrap     = col_next >= w_eff;

      // foreground test wins when the thresholds cross
      if (quot_ff >= fgd_ff) begin
         label = ptbc_pkg::LABEL_PROB_FGD;
      end else if (quot_ff >= bgd_ff) begin
         label = ptbc_pkg::LABEL_PROB_BGD;
      end else begin
         label = ptbc_pkg::LABEL_BGD;
      end
   end

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      quot_in  = quot_ff;
      last_in  = last_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_push) begin
               last_in  = req_data.frame_end;
               rem_in   = numer;
               den_in   = {range, 9'b0};
               cnt_in   = SAT_STEP;
               quot_in  = '0;
               state_in = (flat || low) ? F_SEND : F_DIV;
            end
         end
         F_DIV: begin
            if (cnt_ff == SAT_STEP) begin
               // quotient of 256 or more: saturate the level
               if (ge) begin
                  quot_in  = '1;
                  state_in = F_SEND;
               end else begin
                  den_in = den_ff >> 1;
                  cnt_in = cnt_ff - 4'd1;
               end
            end else begin
               if (ge) begin
                  rem_in = rem_sub;
               end
               quot_in = {quot_ff[ptbc_pkg::LEVEL_W-2:0], ge};
               den_in  = den_ff >> 1;
               if (cnt_ff == '0) begin
                  state_in = F_SEND;
               end else begin
                  cnt_in = cnt_ff - 4'd1;
               end
            end
         end
         F_SEND: begin
            if (!q_full) begin
               state_in = F_IDLE;
               if (last_ff) begin
                  col_in = '0;
                  row_in = '0;
               end else if (wrap) begin
                  col_in = '0;
                  if (row_ff != 12'(ptbc_pkg::HEIGHT_MAX - 1)) begin
                     row_in = row_ff + 12'd1;
                  end
               end else begin
                  col_in = col_next[ptbc_pkg::COORD_W-1:0];
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
      last_ff <= last_in;
   end

   assign req_full      = state_ff != F_IDLE;
   assign q_push        = state_ff == F_SEND;
   assign q_data.label  = label;
   assign q_data.col    = col_ff;
   assign q_data.row    = row_ff;
   assign q_data.last   = last_ff;

endmodule

// ===== rtl/ptbc_queue.sv =====
// Two-entry queue of classified pixels between the front end and the accumulators.
module ptbc_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   output logic                full,
   input  ptbc_pkg::pixel_type data_in,
   input  logic                pop,
   output logic                empty,
   output ptbc_pkg::pixel_type data_out
);

   ptbc_pkg::pixel_type mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full     = count_ff == 2'd2;
      empty    = count_ff == 2'd0;
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      data_out = mem_ff[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= data_in;
      end
   end

endmodule

// ===== rtl/ptbc_sum_div.sv =====
// Restoring divider for the centroid: 36-bit sum over 25-bit count, quotient saturated to 12 bits.
module ptbc_sum_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [ptbc_pkg::SUM_W-1:0]   dividend,
   input  logic [ptbc_pkg::CNT_W-1:0]   divisor,
   output logic                         done,
   output logic [ptbc_pkg::COORD_W-1:0] quotient
);

   localparam logic [3:0] SAT_STEP = 4'd12;

   logic                         busy_ff, busy_in, done_ff, done_in;
   logic [ptbc_pkg::SUM_W-1:0]   rem_ff, rem_in, rem_sub;
   logic [ptbc_pkg::SUM_W:0]     den_ff, den_in;
   logic [3:0]                   cnt_ff, cnt_in;
   logic [ptbc_pkg::COORD_W-1:0] quot_ff, quot_in;
   logic                         ge;

   always_comb begin
      ge      = {1'b0, rem_ff} >= den_ff;
      rem_sub = rem_ff - den_ff[ptbc_pkg::SUM_W-1:0];
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = dividend;
         den_in  = {divisor, 12'b0};
         cnt_in  = SAT_STEP;
         quot_in = '0;
      end else if (busy_ff) begin
         if (cnt_ff == SAT_STEP) begin
            // mean of 4096 or more: clamp
            if (ge) begin
               quot_in = '1;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               den_in = den_ff >> 1;
               cnt_in = cnt_ff - 4'd1;
            end
         end else begin
            if (ge) begin
               rem_in = rem_sub;
            end
            quot_in = {quot_ff[ptbc_pkg::COORD_W-2:0], ge};
            den_in  = den_ff >> 1;
            if (cnt_ff == '0) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff - 4'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      quot_ff <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/ptbc_back.sv =====
// Back end: foreground sums, count and box, frame summary and the result register.
module ptbc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   input  ptbc_pkg::pixel_type q_data,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output ptbc_pkg::rsp_type   rsp_data
);

   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_DIVX = 4'b0010,
      B_DIVY = 4'b0100,
      B_OUT  = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [ptbc_pkg::SUM_W-1:0]   sum_cols_ff, sum_cols_in, sum_rows_ff, sum_rows_in;
   logic [ptbc_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ptbc_pkg::COORD_W-1:0] min_col_ff, min_col_in, min_row_ff, min_row_in;
   logic [ptbc_pkg::COORD_W-1:0] max_col_ff, max_col_in, max_row_ff, max_row_in;
   logic                         seen_ff, seen_in;
   logic [ptbc_pkg::LABEL_W-1:0] label_ff, label_in;
   logic [ptbc_pkg::COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic                         start_ff, start_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ptbc_pkg::rsp_type            rsp_ff, rsp_in;

   logic                         out_free, take, is_fg, no_fg;
   logic [ptbc_pkg::SUM_W:0]     col_sum, row_sum;
   logic [ptbc_pkg::SUM_W-1:0]   div_dividend;
   logic                         div_done;
   logic [ptbc_pkg::COORD_W-1:0] div_quot;

   assign div_dividend = (state_ff == B_DIVY) ? sum_rows_ff : sum_cols_ff;

   ptbc_sum_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (div_dividend),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      out_free = !rsp_valid_ff || rsp_pop;
      // a frame end item waits in the divider states or in B_OUT, so it needs no free slot yet
      take     = (state_ff == B_IDLE) && !q_empty && (q_data.last || out_free);
      is_fg    = q_data.label == ptbc_pkg::LABEL_PROB_FGD;
      no_fg    = !seen_ff || (count_ff == '0);
      col_sum  = {1'b0, sum_cols_ff} + {25'b0, q_data.col};
      row_sum  = {1'b0, sum_rows_ff} + {25'b0, q_data.row};

      state_in     = state_ff;
      sum_cols_in  = sum_cols_ff;
      sum_rows_in  = sum_rows_ff;
      count_in     = count_ff;
      min_col_in   = min_col_ff;
      min_row_in   = min_row_ff;
      max_col_in   = max_col_ff;
      max_row_in   = max_row_ff;
      seen_in      = seen_ff;
      label_in     = label_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      start_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_pop;
      rsp_in       = rsp_ff;

      if (take && is_fg) begin
         sum_cols_in = col_sum[ptbc_pkg::SUM_W] ? '1 : col_sum[ptbc_pkg::SUM_W-1:0];
         sum_rows_in = row_sum[ptbc_pkg::SUM_W] ? '1 : row_sum[ptbc_pkg::SUM_W-1:0];
         if (count_ff != '1) begin
            count_in = count_ff + 25'd1;
         end
         seen_in = 1'b1;
         if (!seen_ff) begin
            min_col_in = q_data.col;
            max_col_in = q_data.col;
            min_row_in = q_data.row;
            max_row_in = q_data.row;
         end else begin
            if (q_data.col < min_col_ff) min_col_in = q_data.col;
            if (q_data.col > max_col_ff) max_col_in = q_data.col;
            if (q_data.row < min_row_ff) min_row_in = q_data.row;
            if (q_data.row > max_row_ff) max_row_in = q_data.row;
         end
      end

      unique case (state_ff)
         B_IDLE: begin
            if (take) begin
               if (q_data.last) begin
                  label_in = q_data.label;
                  if (seen_ff || is_fg) begin
                     start_in = 1'b1;
                     state_in = B_DIVX;
                  end else begin
                     state_in = B_OUT;
                  end
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '0;
                  rsp_in.label = q_data.label;
               end
            end
         end
         B_DIVX: begin
            if (div_done) begin
               cx_in    = div_quot;
               start_in = 1'b1;
               state_in = B_DIVY;
            end
         end
         B_DIVY: begin
            if (div_done) begin
               cy_in    = div_quot;
               state_in = B_OUT;
            end
         end
         B_OUT: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_in               = '0;
               rsp_in.label         = label_ff;
               rsp_in.frame_done    = 1'b1;
               rsp_in.no_foreground = no_fg;
               if (!no_fg) begin
                  rsp_in.centroid_x = cx_ff;
                  rsp_in.centroid_y = cy_ff;
                  rsp_in.box_left   = min_col_ff;
                  rsp_in.box_top    = min_row_ff;
                  rsp_in.box_right  = max_col_ff;
                  rsp_in.box_bottom = max_row_ff;
               end
               // clear the frame for the next one
               sum_cols_in = '0;
               sum_rows_in = '0;
               count_in    = '0;
               min_col_in  = '0;
               min_row_in  = '0;
               max_col_in  = '0;
               max_row_in  = '0;
               seen_in     = 1'b0;
               state_in    = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         sum_cols_ff  <= '0;
         sum_rows_ff  <= '0;
         count_ff     <= '0;
         min_col_ff   <= '0;
         min_row_ff   <= '0;
         max_col_ff   <= '0;
         max_row_ff   <= '0;
         seen_ff      <= 1'b0;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_cols_ff  <= sum_cols_in;
         sum_rows_ff  <= sum_rows_in;
         count_ff     <= count_in;
         min_col_ff   <= min_col_in;
         min_row_ff   <= min_row_in;
         max_col_ff   <= max_col_in;
         max_row_ff   <= max_row_in;
         seen_ff      <= seen_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      label_ff <= label_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      rsp_ff   <= rsp_in;
   end

   assign q_pop     = take;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/pixel_threshold_bbox_centroid.sv =====
// Top level: saliency pixel labeller with foreground centroid and bounding box.
//
// Pixels enter in raster order on the req_ queue port (push/full), one 8.8
// sample each, with frame_end on the frame's last pixel. Every pixel gives one
// result on the rsp_ queue port (empty/pop): its label, and on the frame end
// pixel also the centroid, the box and the no-foreground flag.
// Registers (frame width, sample min/max, two thresholds) are written on the
// csr_ port; the user must write them only while no item is in flight, since
// the block does not enforce this. The front end holds one pixel at a time
// while its 8-bit restoring divider rescales the sample. The divider is
// skipped when the frame is flat or the sample is at or below the minimum,
// stops after its saturation check when the level saturates, and otherwise
// makes the saturation check and then eight quotient bits. A result passes
// the pixel queue and then the result register. A frame end pixel with
// foreground goes on in the back end to one shared 12-bit divider, which
// forms the column mean, then the row mean; a clamping mean ends early.
// A stalled receiver fills the result register, then the two-entry pixel
// queue, after which full stays high. Reset restores the register defaults
// and clears the position counters, sums and box; no item is pending.
module pixel_threshold_bbox_centroid (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_push,
   output logic                                req_full,
   input  ptbc_pkg::req_type                   req_data,
   output logic                                rsp_empty,
   input  logic                                rsp_pop,
   output ptbc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [ptbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ptbc_pkg::SAMPLE_W-1:0]       csr_wdata
);

   ptbc_pkg::csr_type   csr;
   ptbc_pkg::pixel_type front_pix, back_pix;
   logic                q_push, q_full, q_pop, q_empty;

   assign csr.we    = csr_we;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   ptbc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_full   (q_full),
      .q_data   (front_pix)
   );

   ptbc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .full     (q_full),
      .data_in  (front_pix),
      .pop      (q_pop),
      .empty    (q_empty),
      .data_out (back_pix)
   );

   ptbc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (back_pix),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/ptbc_checker.sv =====
// Port-level checks for the pixel labeller, bound to the top level.
module ptbc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_push,
   input logic                           req_full,
   input ptbc_pkg::req_type              req_data,
   input logic                           rsp_empty,
   input logic                           rsp_pop,
   input ptbc_pkg::rsp_type              rsp_data,
   input logic                           csr_we,
   input logic [ptbc_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [ptbc_pkg::SAMPLE_W-1:0]  csr_wdata
);

   // hold a waiting result until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("result changed while stalled");

   // the front end works on one item at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_push && !req_full |=> req_full)
      else $error("input taken while previous item still in the front end");

   a_plain_pixel: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_data.frame_done |->
         !rsp_data.no_foreground && rsp_data.centroid_x == '0 &&
         rsp_data.centroid_y == '0 && rsp_data.box_left == '0 &&
         rsp_data.box_top == '0 && rsp_data.box_right == '0 && rsp_data.box_bottom == '0)
      else $error("summary fields set on an ordinary pixel");

   a_empty_frame: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.no_foreground |->
         rsp_data.frame_done && rsp_data.centroid_x == '0 &&
         rsp_data.centroid_y == '0 && rsp_data.box_left == '0 &&
         rsp_data.box_top == '0 && rsp_data.box_right == '0 && rsp_data.box_bottom == '0)
      else $error("frame without foreground reports a summary");

   a_box_order: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.frame_done && !rsp_data.no_foreground |->
         rsp_data.box_left <= rsp_data.box_right && rsp_data.box_top <= rsp_data.box_bottom)
      else $error("bounding box corners out of order");

endmodule

bind pixel_threshold_bbox_centroid ptbc_checker u_checker (.*);

// ===== dv/pixel_threshold_bbox_centroid_tb.sv =====
// Self-checking testbench for the saliency pixel labeller with centroid and bounding box.
module pixel_threshold_bbox_centroid_tb;

   typedef logic [ptbc_pkg::SAMPLE_W-1:0] sample_type;
   typedef logic [ptbc_pkg::COORD_W-1:0]  coord_type;

   localparam int MAX_REPORTS     = 40;
   localparam int DRAIN_LIMIT     = 100000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam longint unsigned SUM_MAX = (64'd1 << ptbc_pkg::SUM_W) - 1;
   localparam longint unsigned CNT_MAX = (64'd1 << ptbc_pkg::CNT_W) - 1;
   localparam longint unsigned COORD_MAX = (64'd1 << ptbc_pkg::COORD_W) - 1;

   // Rounding ties, threshold edges and saturation at the reset scaling
   localparam sample_type PROBE_SAMPLES [16] = '{
      16'h0000, 16'h0001, 16'd127, 16'd128, 16'd383, 16'd384, 16'd4990, 16'd5119,
      16'd5120, 16'd17791, 16'd17792, 16'd17920, 16'h8000, 16'hAAAA, 16'h5555, 16'hFF00
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_push = 1'b0;
   logic                           req_full;
   ptbc_pkg::req_type              req_data = '0;
   logic                           rsp_empty;
   logic                           rsp_pop = 1'b0;
   ptbc_pkg::rsp_type              rsp_data;
   logic                           csr_we = 1'b0;
   logic [ptbc_pkg::CSR_IDX_W-1:0] csr_index = ptbc_pkg::REG_FRAME_WIDTH;
   sample_type                     csr_wdata = '0;

   // Register copies and frame accumulators of the predictor
   logic [ptbc_pkg::WIDTH_W-1:0] cfg_width;
   sample_type                   cfg_min, cfg_max;
   logic [ptbc_pkg::LEVEL_W-1:0] cfg_fgd, cfg_bgd;
   int unsigned                  at_col, at_row;
   longint unsigned              fg_col_sum, fg_row_sum, fg_pixels;
   int unsigned                  box_l, box_t, box_r, box_b;
   bit                           any_fg;

   ptbc_pkg::req_type pixel_queue [$];
   ptbc_pkg::rsp_type expected_results [$];

   int mismatch_count = 0;
   int pixels_checked = 0;
   int frames_checked = 0;
   int fg_frames = 0;
   int csr_writes = 0;
   int full_cycles = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit hold_off_go = 1'b0;
   bit hold_off_done = 1'b0;
   logic receiver_hold = 1'b0;

   pixel_threshold_bbox_centroid dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_frame_state();
      at_col = 0;
      at_row = 0;
      fg_col_sum = 0;
      fg_row_sum = 0;
      fg_pixels = 0;
      box_l = 0;
      box_t = 0;
      box_r = 0;
      box_b = 0;
      any_fg = 1'b0;
   endfunction

   // Label one pixel, fold it into the frame totals and give the expected result.
   function automatic ptbc_pkg::rsp_type label_and_track(ptbc_pkg::req_type px);
      ptbc_pkg::rsp_type res;
      longint unsigned span, delta, level, cx, cy;
      int unsigned row_len;
      res = '0;
      level = 0;
      if (cfg_max > cfg_min && px.sample > cfg_min) begin
         span = 64'(cfg_max - cfg_min);
         delta = 64'(px.sample - cfg_min);
         level = (510 * delta + span) / (2 * span);
         if (level > 255) level = 255;
      end
      row_len = {19'b0, cfg_width};
      if (row_len == 0) row_len = 1;
      if (row_len > ptbc_pkg::WIDTH_MAX) row_len = ptbc_pkg::WIDTH_MAX;

      if (level >= cfg_fgd) begin
         res.label = ptbc_pkg::LABEL_PROB_FGD;
         fg_col_sum = (fg_col_sum + at_col > SUM_MAX) ? SUM_MAX : fg_col_sum + at_col;
         fg_row_sum = (fg_row_sum + at_row > SUM_MAX) ? SUM_MAX : fg_row_sum + at_row;
         fg_pixels = (fg_pixels + 1 > CNT_MAX) ? CNT_MAX : fg_pixels + 1;
         if (!any_fg) begin
            box_l = at_col;
            box_r = at_col;
            box_t = at_row;
            box_b = at_row;
            any_fg = 1'b1;
         end else begin
            if (at_col < box_l) box_l = at_col;
            if (at_col > box_r) box_r = at_col;
            if (at_row < box_t) box_t = at_row;
            if (at_row > box_b) box_b = at_row;
         end
      end else if (level >= cfg_bgd) begin
         res.label = ptbc_pkg::LABEL_PROB_BGD;
      end else begin
         res.label = ptbc_pkg::LABEL_BGD;
      end

      // Advance the raster position; rows stick at the last one
      at_col++;
      if (at_col >= row_len) begin
         at_col = 0;
         if (at_row < ptbc_pkg::HEIGHT_MAX - 1) at_row++;
      end

      if (px.frame_end) begin
         res.frame_done = 1'b1;
         if (!any_fg || fg_pixels == 0) begin
            res.no_foreground = 1'b1;
         end else begin
            cx = fg_col_sum / fg_pixels;
            cy = fg_row_sum / fg_pixels;
            res.centroid_x = coord_type'((cx > COORD_MAX) ? COORD_MAX : cx);
            res.centroid_y = coord_type'((cy > COORD_MAX) ? COORD_MAX : cy);
            res.box_left   = coord_type'(box_l);
            res.box_top    = coord_type'(box_t);
            res.box_right  = coord_type'(box_r);
            res.box_bottom = coord_type'(box_b);
         end
         clear_frame_state();
      end
      return res;
   endfunction

   function automatic sample_type pick_sample();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 20) return sample_type'($urandom_range(cfg_min, 0));
      if (roll < 30) return sample_type'($urandom_range(16'hFFFF, cfg_max));
      if (roll < 80) return sample_type'($urandom_range(cfg_max, cfg_min));
      return sample_type'($urandom);
   endfunction

   task automatic report_mismatch(string what);
      if (mismatch_count < MAX_REPORTS)
         $display("ERROR at %0t, result %0d: %s", $time, pixels_checked, what);
      mismatch_count++;
   endtask

   task automatic check_field(string name, coord_type got, coord_type want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic check_result(ptbc_pkg::rsp_type got);
      ptbc_pkg::rsp_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result arrived with no item outstanding");
         return;
      end
      want = expected_results.pop_front();
      pixels_checked++;
      if (want.frame_done) begin
         frames_checked++;
         if (!want.no_foreground) fg_frames++;
      end
      check_field("label", coord_type'(got.label), coord_type'(want.label));
      check_field("frame_done", coord_type'(got.frame_done), coord_type'(want.frame_done));
      check_field("no_foreground", coord_type'(got.no_foreground),
                  coord_type'(want.no_foreground));
      check_field("centroid_x", got.centroid_x, want.centroid_x);
      check_field("centroid_y", got.centroid_y, want.centroid_y);
      check_field("box_left", got.box_left, want.box_left);
      check_field("box_top", got.box_top, want.box_top);
      check_field("box_right", got.box_right, want.box_right);
      check_field("box_bottom", got.box_bottom, want.box_bottom);
   endtask

   task automatic queue_pixel(sample_type s, bit last);
      ptbc_pkg::req_type px;
      px.sample = s;
      px.frame_end = last;
      pixel_queue.insert(pixel_queue.size(), px);
   endtask

   // Queue random frames until about budget pixels; now and then leave one open.
   task automatic queue_frames(int budget);
      int len;
      bit leave_open;
      while (budget > 0) begin
         len = ($urandom_range(5) == 0) ? 1 : $urandom_range(2, 36);
         leave_open = ($urandom_range(5) == 0);
         for (int i = 0; i < len; i++)
            queue_pixel(pick_sample(), !leave_open && i == len - 1);
         budget -= len;
      end
   endtask

   task automatic write_reg(logic [ptbc_pkg::CSR_IDX_W-1:0] idx, sample_type value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         ptbc_pkg::REG_FRAME_WIDTH:   cfg_width = value[ptbc_pkg::WIDTH_W-1:0];
         ptbc_pkg::REG_SAMPLE_MIN:    cfg_min = value;
         ptbc_pkg::REG_SAMPLE_MAX:    cfg_max = value;
         ptbc_pkg::REG_FGD_THRESHOLD: cfg_fgd = value[ptbc_pkg::LEVEL_W-1:0];
         ptbc_pkg::REG_BGD_THRESHOLD: cfg_bgd = value[ptbc_pkg::LEVEL_W-1:0];
         default: ;
      endcase
      csr_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_config(sample_type w, sample_type lo, sample_type hi,
                               sample_type fg, sample_type bg);
      write_reg(ptbc_pkg::REG_FRAME_WIDTH, w);
      write_reg(ptbc_pkg::REG_SAMPLE_MIN, lo);
      write_reg(ptbc_pkg::REG_SAMPLE_MAX, hi);
      write_reg(ptbc_pkg::REG_FGD_THRESHOLD, fg);
      write_reg(ptbc_pkg::REG_BGD_THRESHOLD, bg);
   endtask

   // Hold until every queued item went in and every result came back, then settle.
   task automatic wait_drained();
      int guard;
      guard = 0;
      while ((pixel_queue.size() != 0 || req_push || expected_results.size() != 0)
             && guard < DRAIN_LIMIT) begin
         @(negedge clock);
         guard++;
      end
      if (guard >= DRAIN_LIMIT)
         report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Sender: offer queued items, hold each one until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full)
            expected_results.insert(expected_results.size(), label_and_track(req_data));
         if (req_push && req_full) full_cycles++;
         if (!req_push || !req_full) begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_push <= 1'b1;
               req_data <= pixel_queue.pop_front();
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: check each taken result, stall at random or during the hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_data);
         rsp_pop <= !receiver_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Long receiver hold-off so the block backs up and raises full
   initial begin
      wait (hold_off_go);
      @(posedge clock);
      receiver_hold <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clock);
      receiver_hold <= 1'b0;
      hold_off_done = 1'b1;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d results outstanding", expected_results.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int mode;
      int roll;
      sample_type w, lo, hi, fg, bg;

      cfg_width = 13'd640;
      cfg_min = 16'h0000;
      cfg_max = 16'hFF00;
      cfg_fgd = 8'd70;
      cfg_bgd = 8'd20;
      clear_frame_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: empty frame, lone bright pixel, then a frame of probes
      queue_pixel(16'h0000, 1'b1);
      queue_pixel(16'hFFFF, 1'b1);
      foreach (PROBE_SAMPLES[i]) queue_pixel(PROBE_SAMPLES[i], 1'b0);
      queue_pixel(16'hFFFF, 1'b1);
      wait_drained();

      for (int p = 0; p < 12; p++) begin
         case (p)
            0: apply_config(16'd0, 16'h0000, 16'hFFFF, 16'd255, 16'd0);
            1: apply_config(16'd3, 16'h4000, 16'h4000, 16'd0, 16'd255);
            2: apply_config(16'd5, 16'hF000, 16'h1000, 16'd10, 16'd200);
            3: apply_config(16'd1, 16'h00FF, 16'hFF00, 16'd128, 16'd200);
            default: begin
               roll = $urandom_range(9);
               if (roll < 7) w = sample_type'($urandom_range(2, 9));
               else if (roll == 7) w = 16'd1;
               else if (roll == 8) w = 16'h1FFF;
               else w = 16'hFFFF;
               lo = sample_type'($urandom);
               hi = sample_type'($urandom);
               roll = $urandom_range(9);
               if (roll < 6 && lo > hi) {lo, hi} = {hi, lo};
               else if (roll == 6) hi = lo;
               fg = sample_type'($urandom_range(255));
               bg = ($urandom_range(9) < 7) ? sample_type'($urandom_range(fg))
                                            : sample_type'($urandom_range(255));
               apply_config(w, lo, hi, fg, bg);
            end
         endcase
         mode = p % 4;
         case (mode)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            default: begin send_idle_pct = 14; recv_stall_pct = 14; end
         endcase
         // Sender pauses mid-phase until the block is empty
         queue_frames(10);
         wait_drained();
         queue_frames(10);
         wait_drained();
      end

      // Back up the block while the sender keeps offering
      send_idle_pct = 0;
      recv_stall_pct = 0;
      apply_config(16'd6, 16'h1000, 16'hE000, 16'd100, 16'd40);
      hold_off_go = 1'b1;
      queue_frames(50);
      wait (hold_off_done);
      wait_drained();

      $display("Checked %0d pixel results in %0d frames, %0d with foreground, %0d register writes",
               pixels_checked, frames_checked, fg_frames, csr_writes);
      $display("Input backpressure on %0d cycles, %0d mismatches", full_cycles, mismatch_count);
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
